@@ rtl/gbr_pkg.sv @@
// ----------------------------------------------------------------------------
// gbr_pkg: shared definitions of the 3x3 Gaussian blur block
// Constants, types and the filter tap weights used by the blur datapath,
// its output queue and its line-store memory.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int unsigned MaxLineLength   = 2048;
  localparam int unsigned LineLengthReset = 2048;
  localparam int unsigned LineCountReset  = 1;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned Channels = 3;
  localparam int unsigned PixW     = ChanW * Channels;
  localparam int unsigned SumW     = ChanW + 4;
  localparam int unsigned LenCfgW  = 12;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [0:0] {
    CfgLineLength = 1'b0,
    CfgLineCount  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic            last;
    logic [PixW-1:0] rgb;
  } result_t;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } border_t;

  function automatic logic [2:0] tap_weight(input int col, input int row);
    logic [2:0] w;
    w = 3'd1;
    if (col == 1) w = w << 1;
    if (row == 1) w = w << 1;
    return w;
  endfunction

endpackage

@@ rtl/gaussian_blur_3x3_rgb_unit.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_unit: 3x3 Gaussian blur over an RGB pixel stream
// Each result passes the window stage, the sum stage and the output queue; the
// request that completes a pixel's window comes line_length + 1 requests later.
// Throughput: one request per cycle while the queue has room; the line-store
// RAM, with its own read and write ports, holds the upper and middle lines side by side.
// Reset clears the counters, the window and the queue; the line-store RAM is
// not cleared, as border masking hides every entry not yet written in a frame.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb_unit #(
  parameter int unsigned MAX_LINE_LENGTH = gbr_pkg::MaxLineLength
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [gbr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [gbr_pkg::PixW-1:0]     s_tdata_i,  // red_in, green_in, blue_in
  input  logic                         s_tuser_i,  // command
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [gbr_pkg::PixW-1:0]     m_tdata_o,  // red_out, green_out, blue_out
  output logic                         m_tlast_o
);

  localparam int unsigned PW = $clog2(MAX_LINE_LENGTH);
  localparam int unsigned LW = $clog2(MAX_LINE_LENGTH + 1);
  localparam int unsigned IlW = gbr_pkg::CountW + 1;
  localparam int unsigned FcW = $clog2(gbr_pkg::FifoDepth + 1);
  localparam int unsigned PxW = gbr_pkg::PixW;
  localparam int unsigned LenReset = (gbr_pkg::LineLengthReset > MAX_LINE_LENGTH) ?
                                     MAX_LINE_LENGTH : gbr_pkg::LineLengthReset;

  // Configuration.
  logic [LW-1:0]                    len_q, len_d;
  logic [gbr_pkg::CountW-1:0]       cnt_q, cnt_d;
  logic [gbr_pkg::LenCfgW-1:0]      cfg_len;
  logic [gbr_pkg::CountW-1:0]       cfg_cnt;

  // Request stage.
  logic                             accept;
  logic [PW-1:0]                    ip_q;
  logic [IlW-1:0]                   il_q;
  logic [PW-1:0]                    op_q;
  logic [gbr_pkg::CountW-1:0]       ol_q;
  logic                             ip_wrap;
  logic                             op_wrap;
  logic                             last_a;
  logic                             produce_a;
  logic [PxW-1:0]                   pix_a;
  gbr_pkg::border_t                 border_a;

  // Window stage.
  logic                             vb_q;
  logic                             pb_q;
  logic                             lastb_q;
  gbr_pkg::border_t                 border_b_q;
  logic [PxW-1:0]                   pix_b_q;
  logic [PW-1:0]                    ip_b_q;
  logic                             fwd_q;
  logic [2*PxW-1:0]                 fwd_data_q;
  logic [2*PxW-1:0]                 ram_rdata;
  logic [2*PxW-1:0]                 line_rd;
  logic [2*PxW-1:0]                 ram_wdata;
  logic [PxW-1:0]                   win_q [3][3];

  // Sum stage.
  logic                             pc_q;
  logic                             lastc_q;
  gbr_pkg::border_t                 border_c_q;
  logic [gbr_pkg::SumW-1:0]         sum [gbr_pkg::Channels];
  logic                             use_tap;
  gbr_pkg::result_t                 result;
  gbr_pkg::result_t                 out_data;
  logic [FcW-1:0]                   fifo_cnt;

  assign cfg_len = cfg_wdata_i[gbr_pkg::LenCfgW-1:0];
  assign cfg_cnt = cfg_wdata_i[gbr_pkg::CountW-1:0];

  always_comb begin
    len_d = len_q;
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      case (gbr_pkg::cfg_index_e'(cfg_index_i))
        gbr_pkg::CfgLineLength: begin
          if (cfg_len == '0) begin
            len_d = LW'(1);
          end else if (32'(cfg_len) > MAX_LINE_LENGTH) begin
            len_d = LW'(MAX_LINE_LENGTH);
          end else begin
            len_d = LW'(cfg_len);
          end
        end
        gbr_pkg::CfgLineCount: begin
          cnt_d = (cfg_cnt == '0) ? gbr_pkg::CountW'(1) : cfg_cnt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LW'(LenReset);
      cnt_q <= gbr_pkg::CountW'(gbr_pkg::LineCountReset);
    end else begin
      len_q <= len_d;
      cnt_q <= cnt_d;
    end
  end

  // Position bookkeeping of the request stage.
  assign accept    = s_tvalid_i && s_tready_o;
  assign ip_wrap   = (32'(ip_q) + 32'd1) >= 32'(len_q);
  assign op_wrap   = (32'(op_q) + 32'd1) >= 32'(len_q);
  assign last_a    = (il_q == ({1'b0, cnt_q} + IlW'(1))) && (ip_q == '0);
  assign produce_a = (il_q >= IlW'(2)) || ((il_q == IlW'(1)) && (ip_q != '0));
  assign pix_a     = (!s_tuser_i && (il_q < {1'b0, cnt_q})) ? s_tdata_i : '0;

  assign border_a.left   = (op_q != '0);
  assign border_a.right  = !op_wrap;
  assign border_a.top    = (ol_q != '0);
  assign border_a.bottom = (32'(ol_q) + 32'd1) < 32'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip_q <= '0;
      il_q <= '0;
      op_q <= '0;
      ol_q <= '0;
    end else if (cfg_we_i || (accept && last_a)) begin
      ip_q <= '0;
      il_q <= '0;
      op_q <= '0;
      ol_q <= '0;
    end else if (accept) begin
      if (ip_wrap) begin
        ip_q <= '0;
        il_q <= il_q + IlW'(1);
      end else begin
        ip_q <= ip_q + PW'(1);
      end
      if (produce_a) begin
        if (op_wrap) begin
          op_q <= '0;
          ol_q <= ol_q + gbr_pkg::CountW'(1);
        end else begin
          op_q <= op_q + PW'(1);
        end
      end
    end
  end

  // Line store: upper line in the high half, middle line in the low half.
  assign line_rd   = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {line_rd[PxW-1:0], pix_b_q};

  gbr_ram #(
    .WIDTH(2 * PxW),
    .DEPTH(MAX_LINE_LENGTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (vb_q),
    .waddr_i(ip_b_q),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ip_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q  <= 1'b0;
      pb_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      vb_q  <= accept;
      pb_q  <= accept && produce_a;
      fwd_q <= accept && vb_q && (ip_b_q == ip_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lastb_q    <= last_a;
      border_b_q <= border_a;
      pix_b_q    <= pix_a;
      ip_b_q     <= ip_q;
      fwd_data_q <= ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (cfg_we_i) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (vb_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[0][r] <= win_q[1][r];
        win_q[1][r] <= win_q[2][r];
      end
      win_q[2][0] <= line_rd[2*PxW-1:PxW];
      win_q[2][1] <= line_rd[PxW-1:0];
      win_q[2][2] <= pix_b_q;
    end
  end

  // Weighted sum over the window with border masking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 1'b0;
    end else begin
      pc_q <= pb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pb_q) begin
      lastc_q    <= lastb_q;
      border_c_q <= border_b_q;
    end
  end

  always_comb begin
    use_tap = 1'b0;
    for (int ch = 0; ch < gbr_pkg::Channels; ch++) begin
      sum[ch] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        use_tap = !((c == 0 && !border_c_q.left) || (c == 2 && !border_c_q.right) ||
                    (r == 0 && !border_c_q.top) || (r == 2 && !border_c_q.bottom));
        if (use_tap) begin
          for (int ch = 0; ch < gbr_pkg::Channels; ch++) begin
            sum[ch] = sum[ch] + gbr_pkg::SumW'(gbr_pkg::tap_weight(c, r)) *
                      gbr_pkg::SumW'(win_q[c][r][ch*gbr_pkg::ChanW +: gbr_pkg::ChanW]);
          end
        end
      end
    end
  end

  always_comb begin
    result.last = lastc_q;
    for (int ch = 0; ch < gbr_pkg::Channels; ch++) begin
      result.rgb[ch*gbr_pkg::ChanW +: gbr_pkg::ChanW] =
        sum[ch][gbr_pkg::SumW-1 -: gbr_pkg::ChanW];
    end
  end

  gbr_out_fifo #(
    .DEPTH(gbr_pkg::FifoDepth)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (pc_q),
    .push_data_i(result),
    .out_valid_o(m_tvalid_o),
    .out_ready_i(m_tready_i),
    .out_data_o (out_data),
    .count_o    (fifo_cnt)
  );

  assign m_tdata_o = out_data.rgb;
  assign m_tlast_o = out_data.last;

  // A request is taken only while every result in flight has a queue slot.
  assign s_tready_o = (32'(fifo_cnt) + 32'(pb_q) + 32'(pc_q)) < gbr_pkg::FifoDepth;

  a_queue_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fifo_cnt) + 32'(pb_q) + 32'(pc_q)) <= gbr_pkg::FifoDepth)
    else $error("Results in flight exceed the output queue.");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_a) |=> (ip_q == '0 && il_q == '0 && op_q == '0 && ol_q == '0))
    else $error("Counters not cleared after the last request of a frame.");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pb_q && lastb_q) |=> (pc_q && lastc_q))
    else $error("Frame end marker lost between window and sum stages.");

endmodule

@@ rtl/gbr_ram.sv @@
// ----------------------------------------------------------------------------
// gbr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module gbr_ram #(
  parameter int unsigned WIDTH = 2 * gbr_pkg::PixW,
  parameter int unsigned DEPTH = gbr_pkg::MaxLineLength
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gbr_out_fifo.sv @@
// ----------------------------------------------------------------------------
// gbr_out_fifo: result queue of the blur block
// A small register queue that decouples the blur datapath from the output
// stream and reports its fill level for the input flow control.
// ----------------------------------------------------------------------------
module gbr_out_fifo #(
  parameter int unsigned DEPTH = gbr_pkg::FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  gbr_pkg::result_t           push_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output gbr_pkg::result_t           out_data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gbr_pkg::result_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
